// File: sv/gbpa_pkg.sv
// ----------------------------------------------------------------------------
// gbpa_pkg: shared types and constants of the guarded block pool allocator
// Command codes, status codes, the queued command word and the canary pattern.
// ----------------------------------------------------------------------------
package gbpa_pkg;

  localparam int unsigned NUM_BLOCKS_DEF  = 8;
  localparam int unsigned DATA_BYTES_DEF  = 24;
  localparam int unsigned BLOCK_BYTES_DEF = 32;

  // Largest pool is 64 blocks of 256 bytes, so a byte address fits in 14 bits.
  localparam int unsigned ADDR_MAX_W  = 14;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] CANARY_WORD = 32'hDEAD_BEEF;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_CHECK = 3'd2,
    OP_WRITE = 3'd3,
    OP_RESET = 3'd4
  } op_e;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_ILLEGAL = 3'd2;
  localparam logic [2:0] ST_DOUBLE  = 3'd3;
  localparam logic [2:0] ST_CANARY  = 3'd4;
  localparam logic [2:0] ST_CHECK   = 3'd5;

  // One decoded command word as it travels from front to back.
  typedef struct packed {
    op_e                   op;
    logic                  id_ok;
    logic [3:0]            slot_id;
    logic                  in_pool;
    logic [ADDR_MAX_W-1:0] addr;
    logic [7:0]            value;
  } cmd_t;

  // Reasons for the front to hold off new words.
  typedef struct packed {
    logic q_full;
    logic init_busy;
  } hold_t;

  // Byte k of the canary as stored little-endian.
  function automatic logic [7:0] canary_byte(input logic [1:0] k);
    logic [7:0] b;
    b = CANARY_WORD[8*k +: 8];
    return b;
  endfunction

endpackage

// File: sv/gbpa_front.sv
// ----------------------------------------------------------------------------
// gbpa_front: command decoder
// Accepts a word, drops unknown actions, range-checks the id and forms the
// pool byte address of a byte write before queueing the command.
// ----------------------------------------------------------------------------
module gbpa_front #(
  parameter int unsigned NUM_BLOCKS  = gbpa_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = gbpa_pkg::BLOCK_BYTES_DEF
) (
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        action_i,
  input  logic [3:0]        slot_id_i,
  input  logic [6:0]        byte_offset_i,
  input  logic [7:0]        byte_value_i,
  input  gbpa_pkg::hold_t   hold_i,
  output logic              push_o,
  output gbpa_pkg::cmd_t    cmd_o
);
  import gbpa_pkg::*;

  localparam int unsigned POOL_BYTES = NUM_BLOCKS * BLOCK_BYTES;

  logic        known;
  logic        id_ok;
  logic [31:0] addr_full;

  always_comb begin
    unique case (action_i) inside
      OP_ALLOC, OP_FREE, OP_CHECK, OP_WRITE, OP_RESET: known = 1'b1;
      default:                                         known = 1'b0;
    endcase
  end

  assign id_ok     = 32'(slot_id_i) < NUM_BLOCKS;
  assign addr_full = 32'(slot_id_i) * BLOCK_BYTES + 32'd4 + 32'(byte_offset_i);

  assign busy   = hold_i.q_full | hold_i.init_busy;
  // Drop unknown actions: they give no result.
  assign push_o = start & ~busy & known;

  always_comb begin
    cmd_o.op      = op_e'(action_i);
    cmd_o.id_ok   = id_ok;
    cmd_o.slot_id = slot_id_i;
    cmd_o.in_pool = id_ok && (addr_full < POOL_BYTES);
    cmd_o.addr    = addr_full[ADDR_MAX_W-1:0];
    cmd_o.value   = byte_value_i;
  end

endmodule

// File: sv/gbpa_fifo.sv
// ----------------------------------------------------------------------------
// gbpa_fifo: command queue
// A short queue of decoded command words between the decoder and the engine.
// ----------------------------------------------------------------------------
module gbpa_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gbpa_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output gbpa_pkg::cmd_t cmd_o
);
  import gbpa_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("command pushed into a full queue");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command popped from an empty queue");

endmodule

// File: sv/gbpa_back.sv
// ----------------------------------------------------------------------------
// gbpa_back: pool engine
// Owns the pool memory and the live and issued flags, runs each command
// through a small sequencer and raises one result strobe per command.
// ----------------------------------------------------------------------------
module gbpa_back #(
  parameter int unsigned NUM_BLOCKS  = gbpa_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned DATA_BYTES  = gbpa_pkg::DATA_BYTES_DEF,
  parameter int unsigned BLOCK_BYTES = gbpa_pkg::BLOCK_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  gbpa_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           init_o,
  output logic           done_o,
  output logic [2:0]     status_o,
  output logic [2:0]     given_id_o
);
  import gbpa_pkg::*;

  localparam int unsigned POOL_BYTES = NUM_BLOCKS * BLOCK_BYTES;
  localparam int unsigned POOL_ROWS  = (POOL_BYTES + 3) / 4;
  localparam int unsigned ROW_W      = $clog2(POOL_ROWS);
  localparam int unsigned CA_W       = $clog2(POOL_BYTES + 4);
  localparam int unsigned IDX_W      = $clog2(NUM_BLOCKS);
  localparam int unsigned OFF_W      = $clog2(BLOCK_BYTES + 4);
  localparam int unsigned TRAIL_OFF  = DATA_BYTES + 4;
  localparam int unsigned FREE_LIMIT = DATA_BYTES + 8;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_EXEC     = 6'b000010,
    S_RD_LEAD  = 6'b000100,
    S_RD_TRAIL = 6'b001000,
    S_JUDGE    = 6'b010000,
    S_FILL     = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    FM_ALLOC = 2'd0,
    FM_FREE  = 2'd1,
    FM_RESET = 2'd2
  } fill_e;

  state_e            state_q, state_d;
  fill_e             mode_q, mode_d;
  cmd_t              cmd_q, cmd_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CA_W-1:0]   base_q, base_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic              reply_q, reply_d;
  logic              init_q, init_d;
  logic [NUM_BLOCKS-1:0] used_q, used_d;
  logic [NUM_BLOCKS-1:0] issued_q, issued_d;
  logic              lead_ok_q, lead_ok_d;
  logic              res_vld_q, res_vld_d;
  logic [2:0]        res_status_q, res_status_d;
  logic [2:0]        res_given_q, res_given_d;
  logic [1:0]        rot_q;

  // Pool access port: four byte lanes, each addressing its own row.
  logic [CA_W-1:0]   acc_addr;
  logic              acc_wr;
  logic              acc_rd;
  logic [3:0]        acc_mask;
  logic [3:0][7:0]   acc_data;
  logic [3:0]        lane_ok;
  logic              canary_good;

  logic [3:0]        fill_mask;
  logic [3:0][7:0]   fill_data;
  logic [31:0]       fill_limit;
  logic              fill_last;

  logic [IDX_W-1:0]  slot_idx;
  logic [CA_W-1:0]   slot_base;
  logic              live;
  logic              was_issued;
  logic [IDX_W-1:0]  free_idx;
  logic              any_free;
  logic [CA_W-1:0]   free_base;

  assign slot_idx   = IDX_W'(cmd_q.slot_id);
  assign slot_base  = CA_W'(32'(slot_idx) * BLOCK_BYTES);
  assign live       = cmd_q.id_ok && used_q[slot_idx];
  assign was_issued = cmd_q.id_ok && issued_q[slot_idx];
  assign free_base  = CA_W'(32'(free_idx) * BLOCK_BYTES);

  // Lowest block that is not live.
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = IDX_W'(i);
        any_free = 1'b1;
      end
    end
  end

  // Fill pattern for the four bytes at block offset off_q.
  assign fill_limit = (mode_q == FM_RESET) ? 32'(BLOCK_BYTES) : 32'(FREE_LIMIT);
  assign fill_last  = (32'(off_q) + 32'd4) >= fill_limit;

  always_comb begin
    logic [31:0] o32;
    logic [31:0] t32;
    logic        in_lead;
    logic        in_trail;
    for (int k = 0; k < 4; k++) begin
      o32      = 32'(off_q) + 32'(k);
      t32      = o32 - 32'(TRAIL_OFF);
      in_lead  = o32 < 32'd4;
      in_trail = (o32 >= 32'(TRAIL_OFF)) && (o32 < 32'(TRAIL_OFF + 4));
      if (in_lead) begin
        fill_data[k] = canary_byte(o32[1:0]);
      end else if (in_trail) begin
        fill_data[k] = canary_byte(t32[1:0]);
      end else begin
        fill_data[k] = 8'h00;
      end
      fill_mask[k] = (o32 < fill_limit) && ((mode_q != FM_ALLOC) || in_lead || in_trail);
    end
  end

  // Byte lanes: lane l holds pool bytes 4*row + l.
  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [7:0]       mem_q [POOL_ROWS];
    logic [7:0]       rd_q;
    logic [1:0]       k_w;
    logic [1:0]       k_r;
    logic [CA_W-1:0]  b;
    logic [ROW_W-1:0] row;

    assign k_w = 2'(l) - acc_addr[1:0];
    assign b   = acc_addr + CA_W'(k_w);
    assign row = ROW_W'(b >> 2);
    assign k_r = 2'(l) - rot_q;

    always_ff @(posedge clk_i) begin
      if (acc_wr && acc_mask[k_w]) begin
        mem_q[row] <= acc_data[k_w];
      end
      if (acc_rd) begin
        rd_q <= mem_q[row];
      end
    end

    assign lane_ok[l] = rd_q == canary_byte(k_r);
  end

  assign canary_good = &lane_ok;

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    base_d       = base_q;
    off_d        = off_q;
    reply_d      = reply_q;
    init_d       = init_q;
    used_d       = used_q;
    issued_d     = issued_q;
    lead_ok_d    = lead_ok_q;
    res_vld_d    = 1'b0;
    res_status_d = ST_OK;
    res_given_d  = '0;
    pop_o        = 1'b0;
    acc_addr     = base_q;
    acc_wr       = 1'b0;
    acc_rd       = 1'b0;
    acc_mask     = fill_mask;
    acc_data     = fill_data;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_IDLE;
        idx_d   = slot_idx;
        base_d  = slot_base;
        off_d   = '0;
        unique case (cmd_q.op)
          OP_ALLOC: begin
            if (!any_free) begin
              res_vld_d    = 1'b1;
              res_status_d = ST_FULL;
            end else begin
              idx_d              = free_idx;
              base_d             = free_base;
              used_d[free_idx]   = 1'b1;
              issued_d[free_idx] = 1'b1;
              mode_d             = FM_ALLOC;
              reply_d            = 1'b1;
              state_d            = S_FILL;
            end
          end
          OP_FREE: begin
            if (!cmd_q.id_ok) begin
              res_vld_d    = 1'b1;
              res_status_d = ST_ILLEGAL;
            end else if (!live) begin
              res_vld_d    = 1'b1;
              res_status_d = was_issued ? ST_DOUBLE : ST_ILLEGAL;
            end else begin
              state_d = S_RD_LEAD;
            end
          end
          OP_CHECK: begin
            if (!live) begin
              res_vld_d    = 1'b1;
              res_status_d = ST_CHECK;
            end else begin
              state_d = S_RD_LEAD;
            end
          end
          OP_WRITE: begin
            res_vld_d = 1'b1;
            if (!live) begin
              res_status_d = ST_ILLEGAL;
            end else begin
              // Drop a byte that lands past the pool end.
              acc_addr = CA_W'(cmd_q.addr);
              acc_wr   = cmd_q.in_pool;
              acc_mask = 4'b0001;
              acc_data = {4{cmd_q.value}};
            end
          end
          OP_RESET: begin
            used_d   = '0;
            issued_d = '0;
            idx_d    = '0;
            base_d   = '0;
            mode_d   = FM_RESET;
            reply_d  = 1'b1;
            state_d  = S_FILL;
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_RD_LEAD: begin
        acc_rd   = 1'b1;
        acc_addr = base_q;
        state_d  = S_RD_TRAIL;
      end

      S_RD_TRAIL: begin
        acc_rd    = 1'b1;
        acc_addr  = base_q + CA_W'(TRAIL_OFF);
        lead_ok_d = canary_good;
        state_d   = S_JUDGE;
      end

      S_JUDGE: begin
        state_d = S_IDLE;
        if (cmd_q.op == OP_CHECK) begin
          res_vld_d    = 1'b1;
          res_status_d = (lead_ok_q && canary_good) ? ST_OK : ST_CHECK;
        end else if (!(lead_ok_q && canary_good)) begin
          // Keep the block live when a canary is broken.
          res_vld_d    = 1'b1;
          res_status_d = ST_CANARY;
        end else begin
          used_d[idx_q] = 1'b0;
          mode_d        = FM_FREE;
          reply_d       = 1'b1;
          off_d         = '0;
          state_d       = S_FILL;
        end
      end

      S_FILL: begin
        acc_addr = base_q + CA_W'(off_q);
        acc_wr   = 1'b1;
        if (!fill_last) begin
          off_d = off_q + OFF_W'(4);
        end else if (mode_q == FM_RESET && idx_q != IDX_W'(NUM_BLOCKS - 1)) begin
          idx_d  = idx_q + IDX_W'(1);
          base_d = base_q + CA_W'(BLOCK_BYTES);
          off_d  = '0;
        end else begin
          state_d = S_IDLE;
          init_d  = 1'b0;
          if (reply_q) begin
            res_vld_d    = 1'b1;
            res_status_d = ST_OK;
            res_given_d  = (mode_q == FM_ALLOC) ? 3'(idx_q) : 3'd0;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // Come out of reset sweeping the whole pool back to its clean image.
      state_q   <= S_FILL;
      mode_q    <= FM_RESET;
      idx_q     <= '0;
      base_q    <= '0;
      off_q     <= '0;
      reply_q   <= 1'b0;
      init_q    <= 1'b1;
      used_q    <= '0;
      issued_q  <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      idx_q     <= idx_d;
      base_q    <= base_d;
      off_q     <= off_d;
      reply_q   <= reply_d;
      init_q    <= init_d;
      used_q    <= used_d;
      issued_q  <= issued_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    lead_ok_q    <= lead_ok_d;
    res_status_q <= res_status_d;
    res_given_q  <= res_given_d;
    if (acc_rd) begin
      rot_q <= acc_addr[1:0];
    end
  end

  assign init_o     = init_q;
  assign done_o     = res_vld_q;
  assign status_o   = res_status_q;
  assign given_id_o = res_given_q;

  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> !res_vld_q)
    else $error("result raised during the power-on clearing pass");

  a_live_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q & ~issued_q) == '0)
    else $error("live block whose id was never issued");

  a_full_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_status_q == ST_FULL |-> &used_q)
    else $error("pool full reported with a free block");

  a_given_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_given_q != 3'd0 |-> res_status_q == ST_OK)
    else $error("block id given with a failing status");

endmodule

// File: sv/guarded_block_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// guarded_block_pool_allocator_unit: guarded fixed-block pool allocator
// Pool of fixed blocks, each with a leading and a trailing canary word around
// the user bytes; alloc, free, check, byte write and pool reset commands.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                         Payload
// command   in         start high, busy low at the edge  action_i, slot_id_i,
//                                                        byte_offset_i, byte_value_i
// result    out        done_o high for one cycle         status_o, given_id_o
//
// Flow: a command word enters a two-word queue in the cycle it is taken.
// The pool engine decodes it and settles a byte write, a full pool or a
// check/free that fails before touching memory there; a check or free
// reads the leading, then the trailing canary and judges them; an alloc
// writes both canaries, a free rewrites its block through the trailing
// canary and a pool reset rewrites every block; the result strobe is then
// registered. The single port of the pool memory is four byte lanes wide,
// so a canary or four user bytes move per cycle. Reset: after rst_ni rises
// the engine sweeps the pool back to its clean image, with busy held.
// Stalls: busy rises only while the queue is full or the sweep runs; the
// receiver takes every result in the cycle it is shown.
// Unknown actions are taken and dropped without a result.
//
module guarded_block_pool_allocator_unit #(
  parameter int unsigned NUM_BLOCKS  = gbpa_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned DATA_BYTES  = gbpa_pkg::DATA_BYTES_DEF,
  parameter int unsigned BLOCK_BYTES = gbpa_pkg::BLOCK_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] action_i,
  input  logic [3:0] slot_id_i,
  input  logic [6:0] byte_offset_i,
  input  logic [7:0] byte_value_i,
  output logic       done_o,
  output logic [2:0] status_o,
  output logic [2:0] given_id_o
);
  import gbpa_pkg::*;

  hold_t hold;
  logic  push;
  cmd_t  push_cmd;
  logic  q_full;
  logic  q_valid;
  cmd_t  q_cmd;
  logic  pop;
  logic  init_busy;

  // Hold the decoder off while the queue is full or the pool is being swept.
  assign hold.q_full    = q_full;
  assign hold.init_busy = init_busy;

  gbpa_front #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .slot_id_i     (slot_id_i),
    .byte_offset_i (byte_offset_i),
    .byte_value_i  (byte_value_i),
    .hold_i        (hold),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  // Decouple decode from execution so a word can be taken while one runs.
  gbpa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // Run commands against the pool memory and flags; one strobe per command.
  gbpa_back #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .DATA_BYTES  (DATA_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .cmd_i      (q_cmd),
    .pop_o      (pop),
    .init_o     (init_busy),
    .done_o     (done_o),
    .status_o   (status_o),
    .given_id_o (given_id_o)
  );

endmodule

// File: bench/guarded_block_pool_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// guarded_block_pool_allocator_unit_test: self-checking bench for the pool unit
// Drives alloc, free, check, byte write and pool reset words into the block,
// predicts every result from a byte-level shadow of the pool and compares each
// strobed result with the oldest prediction. A short directed run covers the
// corner cases, then three random phases vary how often the sender pauses.
// ----------------------------------------------------------------------------
module guarded_block_pool_allocator_unit_test;
  import gbpa_pkg::*;

  // Pool geometry as built with the default parameters.
  localparam int unsigned NBLK       = NUM_BLOCKS_DEF;
  localparam int unsigned DBYTES     = DATA_BYTES_DEF;
  localparam int unsigned BBYTES     = BLOCK_BYTES_DEF;
  localparam int unsigned POOL_BYTES = NBLK * BBYTES;
  localparam int unsigned HEAD_BYTES = 4;                  // leading canary
  localparam int unsigned TRAIL_OFS  = HEAD_BYTES + DBYTES; // trailing canary
  localparam int unsigned IDX_W      = $clog2(NBLK);
  localparam int unsigned ADDR_W     = $clog2(POOL_BYTES);

  // Action codes the block takes and drops without a result.
  localparam logic [2:0] ACT_SPARE_LO = 3'(OP_RESET) + 3'd1;
  localparam logic [2:0] ACT_SPARE_HI = '1;

  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS  = 610;
  // A pool reset is the slowest word and two may sit in the queue ahead of it,
  // so STALL_LIMIT quiet cycles in a row means a hang.
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES  = 200;
  localparam int unsigned SHOW_FAULTS  = 10;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] slot_id;
    logic [6:0] offset;
    logic [7:0] value;
  } pool_cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] given;
  } pool_reply_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       start         = 1'b0;
  logic       busy;
  logic [2:0] action_i      = '0;
  logic [3:0] slot_id_i     = '0;
  logic [6:0] byte_offset_i = '0;
  logic [7:0] byte_value_i  = '0;
  logic       done_o;
  logic [2:0] status_o;
  logic [2:0] given_id_o;

  guarded_block_pool_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .slot_id_i     (slot_id_i),
    .byte_offset_i (byte_offset_i),
    .byte_value_i  (byte_value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .given_id_o    (given_id_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Words waiting to be driven, and results predicted but not yet seen.
  pool_cmd_t   cmd_backlog[$];
  pool_reply_t pending_replies[$];

  // Shadow of the pool: every byte, plus the live and ever-issued flags.
  logic [7:0]      model_bytes [POOL_BYTES];
  logic [NBLK-1:0] model_live;
  logic [NBLK-1:0] model_issued;

  // Rough view of which blocks the queued stimulus has made live; only steers
  // stimulus towards live blocks, never used for checking.
  logic [NBLK-1:0] guide_live = '0;

  int unsigned sender_idle_pct = 19;
  int unsigned words_queued    = 0;
  int unsigned words_directed  = 0;
  int unsigned words_taken     = 0;
  int unsigned results_seen    = 0;
  int unsigned faults          = 0;
  int unsigned stall_cycles    = 0;
  int unsigned status_tally [8];
  bit          word_taken      = 1'b0;

  // --------------------------------------------------------------------------
  // Pool shadow
  // --------------------------------------------------------------------------

  // Reads past the pool end come back as zero, writes there are dropped.
  function automatic logic [7:0] model_rd(input int unsigned a);
    return (a < POOL_BYTES) ? model_bytes[ADDR_W'(a)] : 8'h00;
  endfunction

  function automatic void model_wr(input int unsigned a, input logic [7:0] v);
    if (a < POOL_BYTES) model_bytes[ADDR_W'(a)] = v;
  endfunction

  // Canaries are stored little-endian byte by byte.
  function automatic void put_canary(input int unsigned a);
    int unsigned k;
    for (k = 0; k < 4; k++) model_wr(a + k, CANARY_WORD[8*k +: 8]);
  endfunction

  function automatic bit canary_intact(input int unsigned a);
    logic [31:0] w;
    int unsigned k;
    for (k = 0; k < 4; k++) w[8*k +: 8] = model_rd(a + k);
    return w == CANARY_WORD;
  endfunction

  function automatic void seal_block(input int unsigned idx);
    put_canary(idx * BBYTES);
    put_canary(idx * BBYTES + TRAIL_OFS);
  endfunction

  function automatic bit guards_ok(input int unsigned idx);
    return canary_intact(idx * BBYTES) && canary_intact(idx * BBYTES + TRAIL_OFS);
  endfunction

  function automatic void pool_model_restore();
    int unsigned a;
    int unsigned b;
    for (a = 0; a < POOL_BYTES; a++) model_bytes[ADDR_W'(a)] = 8'h00;
    for (b = 0; b < NBLK; b++) seal_block(b);
    model_live   = '0;
    model_issued = '0;
  endfunction

  // Apply one taken word to the shadow and queue the result it must produce.
  // Spare action codes change nothing and produce nothing.
  function automatic void pool_model_apply(input pool_cmd_t c);
    pool_reply_t      r;
    int unsigned      base;
    int unsigned      i;
    bit               id_ok;
    bit               live;
    logic [IDX_W-1:0] sidx;
    r.status = ST_OK;
    r.given  = '0;
    id_ok    = c.slot_id < NBLK;
    sidx     = IDX_W'(c.slot_id);
    live     = id_ok && model_live[sidx];
    base     = c.slot_id * BBYTES;
    case (c.action)
      OP_ALLOC: begin
        r.status = ST_FULL;
        for (i = 0; i < NBLK; i++) begin
          if (!model_live[IDX_W'(i)]) begin
            model_live[IDX_W'(i)]   = 1'b1;
            model_issued[IDX_W'(i)] = 1'b1;
            seal_block(i);
            r.status = ST_OK;
            r.given  = i[2:0];
            break;
          end
        end
      end
      OP_FREE: begin
        if (!id_ok) begin
          r.status = ST_ILLEGAL;
        end else if (!live) begin
          // An id handed out earlier and already returned is a double free.
          r.status = model_issued[sidx] ? ST_DOUBLE : ST_ILLEGAL;
        end else if (!guards_ok(c.slot_id)) begin
          r.status = ST_CANARY;   // block stays live
        end else begin
          model_live[sidx] = 1'b0;
          for (i = 0; i < DBYTES; i++) model_wr(base + HEAD_BYTES + i, 8'h00);
          seal_block(c.slot_id);
        end
      end
      OP_CHECK: begin
        r.status = (live && guards_ok(c.slot_id)) ? ST_OK : ST_CHECK;
      end
      OP_WRITE: begin
        // The offset may run over the canaries and into later blocks.
        if (!live) r.status = ST_ILLEGAL;
        else model_wr(base + HEAD_BYTES + c.offset, c.value);
      end
      OP_RESET: begin
        pool_model_restore();
      end
      default: return;
    endcase
    pending_replies.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic push_cmd(input logic [2:0] act, input logic [3:0] sid,
                          input logic [6:0] ofs, input logic [7:0] val);
    pool_cmd_t c;
    c.action  = act;
    c.slot_id = sid;
    c.offset  = ofs;
    c.value   = val;
    cmd_backlog.push_back(c);
    // Spare codes are swallowed by the block and do not count as traffic.
    if (act <= 3'(OP_RESET)) words_queued++;
  endtask

  function automatic int unsigned guide_pick_live();
    int unsigned i;
    if (guide_live == '0) return $urandom_range(NBLK - 1, 0);
    do i = $urandom_range(NBLK - 1, 0); while (!guide_live[IDX_W'(i)]);
    return i;
  endfunction

  // Mostly inside the user area; now and then run over the trailing canary
  // and on into the following blocks.
  function automatic logic [6:0] session_offset();
    if ($urandom_range(9, 0) == 0) return 7'($urandom_range(127, DBYTES));
    return 7'($urandom_range(DBYTES - 1, 0));
  endfunction

  // One well-formed life of a block: alloc, some writes and checks, then
  // usually a free, occasionally a second one.
  task automatic queue_session();
    int unsigned id;
    int unsigned n_ops;
    int unsigned k;
    int unsigned roll;
    id = NBLK;
    for (k = 0; k < NBLK; k++) begin
      if (!guide_live[IDX_W'(k)]) begin
        id = k;
        break;
      end
    end
    push_cmd(OP_ALLOC, 4'($urandom()), 7'($urandom()), 8'($urandom()));
    if (id < NBLK) guide_live[IDX_W'(id)] = 1'b1;
    else id = guide_pick_live();
    n_ops = $urandom_range(6, 1);
    for (k = 0; k < n_ops; k++) begin
      roll = $urandom_range(9, 0);
      if (roll < 6) push_cmd(OP_WRITE, 4'(id), session_offset(), 8'($urandom()));
      else if (roll < 9) push_cmd(OP_CHECK, 4'(id), 7'($urandom()), 8'($urandom()));
      else push_cmd(OP_WRITE, 4'(guide_pick_live()), session_offset(), 8'($urandom()));
    end
    if ($urandom_range(9, 0) < 7) begin
      push_cmd(OP_FREE, 4'(id), 7'($urandom()), 8'($urandom()));
      guide_live[IDX_W'(id)] = 1'b0;
      if ($urandom_range(9, 0) == 0)
        push_cmd(OP_FREE, 4'(id), 7'($urandom()), 8'($urandom()));
    end
  endtask

  // Mostly sessions; the rest is spare codes, pool resets and raw noise
  // with any known action and any id.
  task automatic queue_traffic(input int unsigned target);
    int unsigned goal;
    int unsigned roll;
    goal = words_queued + target;
    while (words_queued < goal) begin
      roll = $urandom_range(99, 0);
      if (roll < 3) begin
        push_cmd(3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)), 4'($urandom()),
                 7'($urandom()), 8'($urandom()));
      end else if (roll < 6) begin
        push_cmd(OP_RESET, 4'($urandom()), 7'($urandom()), 8'($urandom()));
        guide_live = '0;
      end else if (roll < 14) begin
        push_cmd(3'($urandom_range(OP_RESET, OP_ALLOC)), 4'($urandom()),
                 7'($urandom()), 8'($urandom()));
      end else begin
        queue_session();
      end
    end
  endtask

  // Hold until every queued word is taken and every result is in.
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || start || pending_replies.size() != 0)
      @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Driver: change inputs on the falling edge only. Advance to the next word
  // once the current one was taken, or pause at random.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    pool_cmd_t nxt;
    if (rst_ni && (!start || word_taken)) begin
      word_taken = 1'b0;
      if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
        nxt = cmd_backlog.pop_front();
        action_i      <= nxt.action;
        slot_id_i     <= nxt.slot_id;
        byte_offset_i <= nxt.offset;
        byte_value_i  <= nxt.value;
        start         <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample on the rising edge. Predict each taken word, compare each
  // strobed result with the oldest prediction, and watch for a hang.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pool_cmd_t   seen;
    pool_reply_t want;
    bit          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (start && !busy) begin
        seen.action  = action_i;
        seen.slot_id = slot_id_i;
        seen.offset  = byte_offset_i;
        seen.value   = byte_value_i;
        word_taken = 1'b1;
        moved      = 1'b1;
        words_taken++;
        pool_model_apply(seen);
      end
      if (done_o) begin
        moved = 1'b1;
        results_seen++;
        if (pending_replies.size() == 0) begin
          faults++;
          if (faults <= SHOW_FAULTS)
            $display("%0t: result with nothing expected: status %0d given_id %0d",
                     $time, status_o, given_id_o);
        end else begin
          want = pending_replies.pop_front();
          status_tally[want.status]++;
          if (status_o !== want.status || given_id_o !== want.given) begin
            faults++;
            if (faults <= SHOW_FAULTS)
              $display("%0t: mismatch: status exp %0d got %0d, given_id exp %0d got %0d",
                       $time, want.status, status_o, want.given, given_id_o);
          end
        end
      end
      // Count quiet cycles; the post-reset sweep falls well inside the limit.
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                   STALL_LIMIT, pending_replies.size());
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    pool_model_restore();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pool errors, fill to full, writes at both field
    // extremes, a write past the pool end, broken trailing and leading
    // canaries, a double free, an illegal id, a spare code and a pool reset.
    push_cmd(OP_CHECK, 4'd0, 7'd0, 8'h00);
    push_cmd(OP_FREE,  4'd0, 7'd0, 8'h00);
    push_cmd(OP_WRITE, 4'd0, 7'd0, 8'h00);
    push_cmd(OP_WRITE, 4'd15, 7'd127, 8'hFF);
    repeat (NBLK) push_cmd(OP_ALLOC, 4'd0, 7'd0, 8'h00);
    push_cmd(OP_ALLOC, 4'd15, 7'd127, 8'hFF);
    push_cmd(OP_WRITE, 4'd7, 7'd127, 8'hFF);
    push_cmd(OP_WRITE, 4'd0, 7'd23, 8'hA5);
    push_cmd(OP_CHECK, 4'd0, 7'd0, 8'h00);
    push_cmd(OP_WRITE, 4'd1, 7'(DBYTES), 8'h00);
    push_cmd(OP_CHECK, 4'd1, 7'd0, 8'h00);
    push_cmd(OP_FREE,  4'd1, 7'd0, 8'h00);
    push_cmd(OP_WRITE, 4'd2, 7'(BBYTES - HEAD_BYTES), 8'h5A);
    push_cmd(OP_CHECK, 4'd3, 7'd0, 8'h00);
    push_cmd(OP_FREE,  4'd0, 7'd0, 8'h00);
    push_cmd(OP_FREE,  4'd0, 7'd0, 8'h00);
    push_cmd(OP_FREE,  4'd15, 7'd0, 8'h00);
    push_cmd(ACT_SPARE_HI, 4'd15, 7'd127, 8'hFF);
    push_cmd(OP_RESET, 4'd0, 7'd0, 8'h00);
    push_cmd(OP_CHECK, 4'd1, 7'd0, 8'h00);
    words_directed = words_queued;
    wait_drained();

    // Random: light sender pauses, then heavy ones, then none at all.
    queue_traffic(PHASE_ITEMS);
    wait_drained();
    sender_idle_pct = 55;
    queue_traffic(PHASE_ITEMS);
    wait_drained();
    sender_idle_pct = 0;
    queue_traffic(PHASE_ITEMS);
    wait_drained();

    // Give a stray late result time to show up.
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d words (%0d directed) over three pause profiles, %0d results checked",
             words_taken, words_directed, results_seen);
    $display("Statuses: ok %0d, full %0d, illegal %0d, double %0d, canary %0d, check %0d",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_ILLEGAL],
             status_tally[ST_DOUBLE], status_tally[ST_CANARY], status_tally[ST_CHECK]);
    if (faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d faults", faults);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
